// ===== sv/rmsn_pkg.sv =====
// rmsn_pkg: shared types, constants and helpers for the RMS row normalizer.
// Depends on nothing; rms_row_normalizer and rmsn_row_buf import it.
`default_nettype none
package rmsn_pkg;
   localparam int MAX_ROW_DEF      = 64;
   localparam int NEWTON_STEPS_DEF = 4;
   localparam int CSR_AW           = 4;
   localparam int SUM_W            = 38;

   localparam logic [CSR_AW-1:0] REG_ROW_LENGTH = 4'h0;
   localparam logic [CSR_AW-1:0] REG_USE_SCALE  = 4'h4;
   localparam logic [CSR_AW-1:0] REG_EPSILON    = 4'h8;

   typedef enum logic [3:0] {
      ST_LOAD, ST_DIV, ST_NORM, ST_NEWT, ST_EMIT_RD, ST_EMIT_M1, ST_EMIT_M2,
      ST_EMIT_OUT
   } state_type;

   // control bundle from sequencer to row buffer
   typedef struct packed {
      logic       wr_en;
      logic [5:0] wr_addr;
      logic       rd_en;
      logic [5:0] rd_addr;
   } buf_ctl_type;
endpackage
`default_nettype wire

// ===== sv/rmsn_stream_if.sv =====
// rmsn_stream_if: valid/ready channel carrying a payload of width W.
// Depends on nothing.
`default_nettype none
interface rmsn_stream_if #(parameter int W = 32) (input wire logic clock);
   logic         valid;
   logic         ready;
   logic [W-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== sv/rms_row_normalizer.sv =====
// rms_row_normalizer: top level, sequencer, divider, Newton unit and output.
// Depends on rmsn_pkg, rmsn_stream_if, rmsn_row_buf.
//
//  channel | dir | payload
//  req     | in  | value[15:0], scale[15:0]
//  rsp     | out | out_value[15:0], clipped, row_end
//  csr     | in  | APB row_length 0x0, use_scale 0x4, epsilon 0x8
//
// Load: one element per cycle; the row-closing element starts the tail.
// Tail: a serial restoring divide, then normalization of the mean square
// (Newton is skipped when the mean square plus epsilon is zero), then
// Newton steps (multiplier shared), then each element passes EMIT_RD, EMIT_M1,
// EMIT_M2 and EMIT_OUT, which waits on rsp stalls. Input is held off during the tail.
// Reset is synchronous; memory contents are not cleared.
`default_nettype none
module rms_row_normalizer #(
   parameter int MAX_ROW      = rmsn_pkg::MAX_ROW_DEF,
   parameter int NEWTON_STEPS = rmsn_pkg::NEWTON_STEPS_DEF
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   rmsn_stream_if.sink                     req,
   rmsn_stream_if.source                   rsp,
   input  wire logic                       csr_psel,
   input  wire logic                       csr_penable,
   input  wire logic                       csr_pwrite,
   input  wire logic [rmsn_pkg::CSR_AW-1:0] csr_paddr,
   input  wire logic [31:0]                csr_pwdata,
   output logic [31:0]                     csr_prdata,
   output logic                            csr_pready
);
   import rmsn_pkg::*;
   localparam int AW = $clog2(MAX_ROW);
   localparam int SW = $clog2(NEWTON_STEPS + 1);

   // ---------------- configuration registers
   logic [6:0]  row_length_ff;
   logic        use_scale_ff;
   logic [15:0] epsilon_ff;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_length_ff <= 7'd64;
         use_scale_ff  <= 1'b1;
         epsilon_ff    <= 16'd17;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         unique case (csr_paddr)
            REG_ROW_LENGTH: row_length_ff <= csr_pwdata[6:0];
            REG_USE_SCALE:  use_scale_ff  <= csr_pwdata[0];
            REG_EPSILON:    epsilon_ff    <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr)
         REG_ROW_LENGTH: csr_prdata = {25'd0, row_length_ff};
         REG_USE_SCALE:  csr_prdata = {31'd0, use_scale_ff};
         REG_EPSILON:    csr_prdata = {16'd0, epsilon_ff};
         default:        csr_prdata = 32'd0;
      endcase
   end

   // effective row length, clamped to 1..MAX_ROW
   logic [6:0] len_eff;
   always_comb begin
      if (row_length_ff == 7'd0) len_eff = 7'd1;
      else if (row_length_ff > 7'(MAX_ROW)) len_eff = 7'(MAX_ROW);
      else len_eff = row_length_ff;
   end

   // ---------------- state
   state_type   state_ff, state_in;
   logic [SUM_W-1:0] sum_ff;
   logic [6:0]  count_ff;
   logic [6:0]  n_ff;              // elements held in closed row
   logic [6:0]  idx_ff;
   logic [5:0]  bit_ff;            // divider bit counter
   logic [SUM_W-1:0] quo_ff;
   logic [6:0]  rem_ff;
   logic [SUM_W-1:0] dvd_ff;
   logic [SUM_W-1:0] m_ff;
   logic signed [5:0] k_ff;
   logic        zero_ff;
   logic        us_ff;
   logic [33:0] y_ff;
   logic [31:0] x_ff;
   logic [2:0]  ph_ff;             // Newton phase
   logic [SW-1:0] step_ff;
   logic [63:0] p_ff;              // shared product register
   logic [63:0] t_ff;
   logic [31:0] inv_ff;
   logic        neg_ff;
   logic [15:0] sv_ff;
   logic [47:0] mag_ff;
   logic [15:0] ov_ff;
   logic        oc_ff, oe_ff, ovalid_ff;

   logic [15:0] in_value, in_scale;
   assign in_value = req.data[15:0];
   assign in_scale = req.data[31:16];

   assign req.ready = (state_ff == ST_LOAD);
   logic take;
   assign take = req.valid && req.ready;

   // ---------------- row buffer
   buf_ctl_type ctl;
   logic [31:0] rd_data;
   always_comb begin
      ctl.wr_en   = take;
      ctl.wr_addr = 6'(count_ff[AW-1:0]);
      ctl.rd_en   = (state_ff == ST_EMIT_RD);
      ctl.rd_addr = 6'(idx_ff[AW-1:0]);
   end
   rmsn_row_buf #(.MAX_ROW(MAX_ROW)) u_buf (
      .clock(clock), .ctl(ctl), .wr_data({in_scale, in_value}), .rd_data(rd_data));

   logic signed [31:0] sq;
   assign sq = $signed(in_value) * $signed(in_value);

   // Newton datapath pieces
   logic [63:0] mul_a, mul_b, prod;
   always_comb begin
      mul_a = 64'd0; mul_b = 64'd0;
      unique case (ph_ff)
         3'd0: begin mul_a = {30'd0, y_ff}; mul_b = {30'd0, y_ff}; end
         3'd1: begin mul_a = {32'd0, x_ff}; mul_b = p_ff >> 30; end
         3'd3: begin mul_a = {30'd0, y_ff}; mul_b = t_ff; end
         default: ;
      endcase
   end
   assign prod = mul_a[33:0] * mul_b[33:0];

   logic [15:0] vabs;
   logic [31:0] rdv;
   assign rdv  = rd_data;
   assign vabs = rdv[15] ? 16'(-rdv[15:0]) : rdv[15:0];
   logic [15:0] sabs;
   assign sabs = sv_ff[15] ? 16'(-sv_ff) : sv_ff;

   logic [6:0]  sh;
   logic [63:0] magw, rnd;
   always_comb begin
      sh   = us_ff ? 7'(42 - k_ff) : 7'(30 - k_ff);
      magw = us_ff ? ({16'd0, mag_ff} * {48'd0, sabs}) : {16'd0, mag_ff};
      rnd  = (magw + (64'd1 << (sh - 7'd1))) >> sh;
   end

   // element being presented is the last of the row
   logic last_emit;
   assign last_emit = (idx_ff + 7'd1 == n_ff);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_LOAD:     if (take && (count_ff + 7'd1 >= len_eff ||
                                   count_ff + 7'd1 >= 7'(MAX_ROW))) state_in = ST_DIV;
         ST_DIV:      if (bit_ff == 6'd0) state_in = ST_NORM;
         ST_NORM:     if (zero_ff || (m_ff < (SUM_W'(1) << 24) &&
                                      m_ff >= (SUM_W'(1) << 22))) state_in =
                         zero_ff ? ST_EMIT_RD : ST_NEWT;
         ST_NEWT:     if (ph_ff == 3'd4 && step_ff == SW'(NEWTON_STEPS - 1))
                         state_in = ST_EMIT_RD;
         ST_EMIT_RD:  state_in = ST_EMIT_M1;
         ST_EMIT_M1:  state_in = ST_EMIT_M2;
         ST_EMIT_M2:  state_in = ST_EMIT_OUT;
         ST_EMIT_OUT: if (!ovalid_ff || rsp.ready)
                         state_in = last_emit ? ST_LOAD : ST_EMIT_RD;
         default:     state_in = ST_LOAD;
      endcase
   end

   logic [SUM_W-1:0] rem_sh;
   assign rem_sh = {31'd0, rem_ff} << 1 | SUM_W'(dvd_ff[SUM_W-1]);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_LOAD;
         sum_ff    <= '0;
         count_ff  <= '0;
         ovalid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         // EMIT_OUT handles the output register itself
         if (ovalid_ff && rsp.ready && state_ff != ST_EMIT_OUT) ovalid_ff <= 1'b0;
         unique case (state_ff)
            ST_LOAD: if (take) begin
               sum_ff   <= sum_ff + SUM_W'(unsigned'(sq));
               count_ff <= count_ff + 7'd1;
               if (state_in == ST_DIV) begin
                  dvd_ff <= sum_ff + SUM_W'(unsigned'(sq));
                  n_ff   <= count_ff + 7'd1;
                  bit_ff <= 6'(SUM_W - 1);
                  rem_ff <= '0;
                  quo_ff <= '0;
                  us_ff  <= use_scale_ff;
               end
            end
            ST_DIV: begin
               // restoring division, one quotient bit per cycle
               dvd_ff <= dvd_ff << 1;
               if (rem_sh >= SUM_W'(n_ff)) begin
                  rem_ff <= 7'(rem_sh - SUM_W'(n_ff));
                  quo_ff <= (quo_ff << 1) | SUM_W'(1);
               end else begin
                  rem_ff <= rem_sh[6:0];
                  quo_ff <= quo_ff << 1;
               end
               bit_ff <= bit_ff - 6'd1;
               if (bit_ff == 6'd0) begin
                  m_ff <= ((rem_sh >= SUM_W'(n_ff)) ? ((quo_ff << 1) | SUM_W'(1))
                          : (quo_ff << 1)) + SUM_W'(epsilon_ff);
                  zero_ff <= 1'b0;
                  k_ff <= '0;
                  sum_ff <= '0;
                  count_ff <= '0;
               end
            end
            ST_NORM: begin
               if (m_ff == '0) begin
                  zero_ff <= 1'b1;
                  inv_ff  <= 32'hFFFF_FFFF;
                  idx_ff  <= '0;
               end else if (m_ff >= (SUM_W'(1) << 24)) begin
                  m_ff <= m_ff >> 2; k_ff <= k_ff - 6'sd1;
               end else if (m_ff < (SUM_W'(1) << 22)) begin
                  m_ff <= m_ff << 2; k_ff <= k_ff + 6'sd1;
               end else begin
                  x_ff    <= {m_ff[23:0], 8'd0};
                  y_ff    <= 34'(64'd9 << 28) - 34'(({32'd0, m_ff[23:0], 8'd0} * 64'd5) >> 4);
                  ph_ff   <= 3'd0;
                  step_ff <= '0;
                  idx_ff  <= '0;
               end
            end
            ST_NEWT: begin
               unique case (ph_ff)
                  3'd0: begin p_ff <= prod; ph_ff <= 3'd1; end
                  3'd1: begin p_ff <= prod >> 32; ph_ff <= 3'd2; end
                  3'd2: begin
                     t_ff  <= (64'(3) << 30 > p_ff) ? (64'(3) << 30) - p_ff : 64'd0;
                     ph_ff <= 3'd3;
                  end
                  3'd3: begin p_ff <= prod >> 31; ph_ff <= 3'd4; end
                  3'd4: begin
                     if (p_ff > (64'd2 << 30)) y_ff <= 34'(64'd2 << 30);
                     else y_ff <= p_ff[33:0];
                     if (p_ff > (64'd2 << 30)) inv_ff <= 32'h8000_0000;
                     else inv_ff <= p_ff[31:0];
                     ph_ff   <= 3'd0;
                     step_ff <= step_ff + SW'(1);
                  end
                  default: ph_ff <= 3'd0;
               endcase
            end
            ST_EMIT_M1: begin
               neg_ff <= rdv[15];
               sv_ff  <= rdv[31:16];
               mag_ff <= {32'd0, vabs} * {16'd0, inv_ff};
            end
            ST_EMIT_M2: begin
               neg_ff <= us_ff ? (neg_ff ^ sv_ff[15]) : neg_ff;
               if (zero_ff) t_ff <= (magw != 64'd0) ? 64'hFFFF_FFFF : 64'd0;
               else t_ff <= rnd;
            end
            ST_EMIT_OUT: if (!ovalid_ff || rsp.ready) begin
               ovalid_ff <= 1'b1;
               if (neg_ff) begin
                  if (t_ff > 64'd32768) begin ov_ff <= 16'h8000; oc_ff <= 1'b1; end
                  else begin ov_ff <= 16'(-t_ff[15:0]); oc_ff <= 1'b0; end
               end else begin
                  if (t_ff > 64'd32767) begin ov_ff <= 16'h7FFF; oc_ff <= 1'b1; end
                  else begin ov_ff <= t_ff[15:0]; oc_ff <= 1'b0; end
               end
               oe_ff  <= last_emit;
               idx_ff <= idx_ff + 7'd1;
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      rsp.valid = ovalid_ff;
      rsp.data  = {oe_ff, oc_ff, ov_ff};
   end
endmodule
`default_nettype wire

// ===== sv/rmsn_row_buf.sv =====
// rmsn_row_buf: row memory holding value and scale per column.
// Depends on rmsn_pkg.
`default_nettype none
module rmsn_row_buf #(parameter int MAX_ROW = 64) (
   input  wire logic                 clock,
   input  wire rmsn_pkg::buf_ctl_type ctl,
   input  wire logic [31:0]          wr_data,
   output logic [31:0]               rd_data
);
   import rmsn_pkg::*;
   localparam int AW = $clog2(MAX_ROW);
   logic [31:0] mem [MAX_ROW];

   // one write and one registered read port
   always_ff @(posedge clock) begin
      if (ctl.wr_en) mem[ctl.wr_addr[AW-1:0]] <= wr_data;
      if (ctl.rd_en) rd_data <= mem[ctl.rd_addr[AW-1:0]];
   end
endmodule
`default_nettype wire
